@@ hdl/mbd_pkg.sv @@
// Package for the multi-button debouncer: lane count, field widths and the
// per-lane status type. No dependencies.
package mbd_pkg;

  localparam int unsigned NumButtons = 16;
  localparam int unsigned LanesMax   = 16;
  localparam int unsigned PortWidth  = 8;
  localparam int unsigned TimeWidth  = 32;
  localparam int unsigned SettleWidth = 16;

  localparam logic [SettleWidth-1:0] SettleReset = SettleWidth'(50);

  typedef logic [LanesMax-1:0]    lane_vec_t;
  typedef logic [TimeWidth-1:0]   stamp_t;
  typedef logic [SettleWidth-1:0] settle_t;
  typedef logic [PortWidth-1:0]   port_t;

  // What one lane reports to the merging stage
  typedef struct packed {
    logic stable;       // debounced state held now
    logic next_stable;  // debounced state after the beat on offer
  } lane_status_t;

endpackage

@@ hdl/mbd_if.sv @@
// Channel interfaces of the debouncer: poll input, result output and the
// settle-time write channel. Depends on mbd_pkg.

interface mbd_poll_if;
  logic           valid;
  logic           ready;
  mbd_pkg::port_t port_a_raw;
  mbd_pkg::port_t port_b_raw;
  mbd_pkg::stamp_t now_ms;

  modport source (output valid, output port_a_raw, output port_b_raw, output now_ms,
                  input ready);
  modport sink   (input valid, input port_a_raw, input port_b_raw, input now_ms,
                  output ready);
endinterface

interface mbd_result_if;
  logic               valid;
  logic               ready;
  mbd_pkg::lane_vec_t debounced_buttons;
  mbd_pkg::lane_vec_t changed_mask;

  modport source (output valid, output debounced_buttons, output changed_mask,
                  input ready);
  modport sink   (input valid, input debounced_buttons, input changed_mask,
                  output ready);
endinterface

interface mbd_cfg_if;
  logic             valid;
  logic             ready;
  mbd_pkg::settle_t settle_time_ms;

  modport source (output valid, output settle_time_ms, input ready);
  modport sink   (input valid, input settle_time_ms, output ready);
endinterface

@@ hdl/mbd_lane.sv @@
// One debounce lane: last sample, time of its last change and debounced bit.
// Depends on mbd_pkg.
module mbd_lane (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  en_i,
  input  logic                  sample_i,
  input  mbd_pkg::stamp_t       now_ms_i,
  input  mbd_pkg::settle_t      settle_i,
  output mbd_pkg::lane_status_t status_o
);

  logic            prev_q, prev_d;
  logic            stable_q, stable_d;
  mbd_pkg::stamp_t stamp_q, stamp_d;
  mbd_pkg::stamp_t elapsed;

  // wrapping difference, so a time that runs backwards reads as a long wait
  assign elapsed = now_ms_i - stamp_q;

  always_comb begin
    prev_d   = prev_q;
    stamp_d  = stamp_q;
    stable_d = stable_q;
    if (sample_i != prev_q) begin
      prev_d  = sample_i;
      stamp_d = now_ms_i;
    end else if (elapsed >= {{(mbd_pkg::TimeWidth-mbd_pkg::SettleWidth){1'b0}}, settle_i}) begin
      stable_d = sample_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      prev_q   <= 1'b0;
      stable_q <= 1'b0;
      stamp_q  <= '0;
    end else if (en_i) begin
      prev_q   <= prev_d;
      stable_q <= stable_d;
      stamp_q  <= stamp_d;
    end
  end

  assign status_o.stable      = stable_q;
  assign status_o.next_stable = stable_d;

endmodule

@@ hdl/mbd_merge.sv @@
// Merging stage: gathers the lanes' debounced bits into the result beat and
// holds it in the output register. Depends on mbd_pkg and mbd_if.
module mbd_merge (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  take_i,
  input  mbd_pkg::lane_status_t lanes_i [mbd_pkg::LanesMax],
  output logic                  space_o,
  mbd_result_if.source          result_o
);

  logic               valid_q, valid_d;
  mbd_pkg::lane_vec_t buttons_q, changed_q;
  mbd_pkg::lane_vec_t now_vec, next_vec;

  always_comb begin
    for (int i = 0; i < int'(mbd_pkg::LanesMax); i++) begin
      now_vec[i]  = lanes_i[i].stable;
      next_vec[i] = lanes_i[i].next_stable;
    end
  end

  // a new beat may enter when the register is empty or drains this cycle
  assign space_o = !valid_q || result_o.ready;

  always_comb begin
    valid_d = valid_q;
    if (take_i) begin
      valid_d = 1'b1;
    end else if (result_o.ready) begin
      valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (take_i) begin
      buttons_q <= next_vec;
      changed_q <= next_vec ^ now_vec;
    end
  end

  assign result_o.valid             = valid_q;
  assign result_o.debounced_buttons = buttons_q;
  assign result_o.changed_mask      = changed_q;

endmodule

@@ hdl/multi_button_time_debouncer.sv @@
// Sixteen-button timestamp debouncer: polls two active-low ports, reports
// the debounced vector and the lanes that changed on each poll.
// Usage:
//   poll_i   : one beat per poll, carrying port_a_raw, port_b_raw (active
//              low, port A is buttons 0..7, port B buttons 8..15) and now_ms.
//   result_o : one beat per poll with debounced_buttons (1 = pressed) and
//              changed_mask (lanes whose debounced bit moved on that poll).
//   cfg_i    : writes settle_time_ms, the time a sample must stay unchanged
//              before it is accepted; always ready, write only while idle.
// A taken poll's result is registered and is on result_o in the next cycle.
// Throughput is one poll per cycle unless result_o stalls; all sixteen lanes
// update in parallel when a poll is taken; one output register holds the result.
// When the receiver stalls, the held beat stays and poll_i.ready stays low
// until it is taken; a poll arriving in the cycle the beat drains is taken.
// Reset clears every lane (nothing pressed, stamps at zero), empties the
// output register and sets settle_time_ms to 50.
// Depends on mbd_pkg, mbd_if, mbd_lane and mbd_merge.
module multi_button_time_debouncer (
  input  logic         clk_i,
  input  logic         rst_ni,
  mbd_poll_if.sink     poll_i,
  mbd_result_if.source result_o,
  mbd_cfg_if.sink      cfg_i
);

  logic                  take;
  logic                  space;
  mbd_pkg::settle_t      settle_q;
  mbd_pkg::lane_vec_t    pressed;
  mbd_pkg::lane_status_t lane_status [mbd_pkg::LanesMax];

  assign cfg_i.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      settle_q <= mbd_pkg::SettleReset;
    end else if (cfg_i.valid) begin
      settle_q <= cfg_i.settle_time_ms;
    end
  end

  assign poll_i.ready = space;
  assign take         = poll_i.valid && space;
  assign pressed      = ~{poll_i.port_b_raw, poll_i.port_a_raw};

  for (genvar i = 0; i < int'(mbd_pkg::LanesMax); i++) begin : g_lane
    if (i < int'(mbd_pkg::NumButtons)) begin : g_active
      mbd_lane u_lane (
        .clk_i    (clk_i),
        .rst_ni   (rst_ni),
        .en_i     (take),
        .sample_i (pressed[i]),
        .now_ms_i (poll_i.now_ms),
        .settle_i (settle_q),
        .status_o (lane_status[i])
      );
    end else begin : g_idle
      // lanes beyond the button count stay released
      assign lane_status[i] = '0;
    end
  end

  mbd_merge u_merge (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .take_i   (take),
    .lanes_i  (lane_status),
    .space_o  (space),
    .result_o (result_o)
  );

endmodule

@@ hdl/mbd_checker.sv @@
// Port-level checks for the debouncer, bound to the top level.
// Depends on multi_button_time_debouncer and mbd_if.
module mbd_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        poll_valid_i,
  input logic        poll_ready_i,
  input logic        res_valid_i,
  input logic        res_ready_i,
  input logic [31:0] res_data_i
);

  logic poll_beat;
  logic res_beat;

  assign poll_beat = poll_valid_i && poll_ready_i;
  assign res_beat  = res_valid_i && res_ready_i;

  // a stalled result beat holds
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_i && !res_ready_i |=> res_valid_i && $stable(res_data_i))
    else $error("result beat dropped or changed while stalled");

  // every poll yields a result on the next cycle
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    poll_beat |=> res_valid_i)
    else $error("poll taken but no result followed");

  // no result appears without a poll
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !res_valid_i && !poll_beat |=> !res_valid_i)
    else $error("result invented without a poll");

  // a delivered result is not repeated
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_beat && !poll_beat |=> !res_valid_i)
    else $error("result repeated after delivery");

  // polls are refused only while a result is stalled
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !poll_ready_i |-> res_valid_i && !res_ready_i)
    else $error("poll refused with room in the output register");

endmodule

bind multi_button_time_debouncer mbd_checker u_mbd_checker (
  .clk_i        (clk_i),
  .rst_ni       (rst_ni),
  .poll_valid_i (poll_i.valid),
  .poll_ready_i (poll_i.ready),
  .res_valid_i  (result_o.valid),
  .res_ready_i  (result_o.ready),
  .res_data_i   ({result_o.debounced_buttons, result_o.changed_mask})
);
